@@ rtl/dag_pkg.sv @@
// shared types, constants and the log2 squaring step for the distance gain block
// no dependencies
package dag_pkg;

    localparam logic [15:0] FULL_GAIN = 16'h8000;
    localparam logic [15:0] LN2_Q16 = 16'd45426;
    localparam logic [29:0] LOG2_10_OVER_20 = 30'd713378625;
    localparam logic [20:0] NAT_TOP = 21'd983040;   // 15.0 in log2 units

    localparam int DIV_STEPS = 16;
    localparam int LOG_STEPS = 16;
    localparam int TRIALS = 14;
    localparam int SRCH_STAGES = TRIALS * LOG_STEPS;

    typedef enum logic [2:0] {
        CURVE_LINEAR  = 3'd0,
        CURVE_LOG     = 3'd1,
        CURVE_INVERSE = 3'd2,
        CURVE_LOG_REV = 3'd3,
        CURVE_NATURAL = 3'd4,
        CURVE_CUSTOM  = 3'd5
    } t_curve;

    typedef enum logic [2:0] {
        CFG_ENABLE  = 3'd0,
        CFG_INNER   = 3'd1,
        CFG_FALLOFF = 3'd2,
        CFG_CURVE   = 3'd3,
        CFG_DB      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic        valid;
        logic        spec;
        logic [15:0] spec_gain;
    } t_meta;

    typedef struct packed {
        logic        bit_set;
        logic [30:0] x;
    } t_sq;

    // one stage of the natural-sound search
    typedef struct packed {
        t_meta       meta;
        logic        nat;
        logic [15:0] gain_other;
        logic [3:0]  p;
        logic [15:0] tf;
        logic [30:0] xg;
        logic [30:0] xt;
        logic [30:0] xs;
        logic [15:0] frac;
        logic        tr_en;
    } t_srch;

    // x is Q1.30 in [1,2): square, renormalize, give the next fraction bit
    function automatic t_sq sq_step(input logic [30:0] x);
        logic [61:0] p;
        logic [31:0] y;
        t_sq         r;
        p = 62'(x) * 62'(x);
        y = p[61:30];
        if (y[31]) begin
            r.bit_set = 1'b1;
            r.x = y[31:1];
        end else begin
            r.bit_set = 1'b0;
            r.x = y[30:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/dag_in_if.sv @@
// distance input channel: valid/ready with one Q16.8 distance per beat
// no dependencies
interface dag_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] distance;
    modport source (output valid, output distance, input ready);
    modport sink (input valid, input distance, output ready);
endinterface

@@ rtl/dag_out_if.sv @@
// gain output channel: valid/ready with one Q1.15 gain per beat
// no dependencies
interface dag_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] gain;
    modport source (output valid, output gain, input ready);
    modport sink (input valid, input gain, output ready);
endinterface

@@ rtl/dag_nat_search.sv @@
// natural-sound gain search: greedy bit search of the largest gain whose log2 fits the target
// uses dag_pkg (t_srch, sq_step)
module dag_nat_search (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  dag_pkg::t_srch i_st,
    output logic           o_valid,
    output logic [15:0]    o_gain
);

    dag_pkg::t_srch r_st [1:dag_pkg::SRCH_STAGES];
    logic           r_fin_v;
    logic [15:0]    r_fin_g;

    genvar s;
    generate
        for (s = 1; s <= dag_pkg::SRCH_STAGES; s++) begin : g_stage
            localparam int TRIAL = (s - 1) / dag_pkg::LOG_STEPS + 1;
            localparam int STEP = (s - 1) % dag_pkg::LOG_STEPS;
            localparam logic [30:0] TRIAL_BIT = 31'd1 << (30 - TRIAL);
            dag_pkg::t_srch w_prev;
            dag_pkg::t_srch n_st;
            dag_pkg::t_sq   w_sq;
            logic           w_acc;
            logic [30:0]    w_xs;

            if (s == 1) begin : g_first
                assign w_prev = i_st;
            end else begin : g_next
                assign w_prev = r_st[s-1];
            end

            always_comb begin
                n_st = w_prev;
                w_acc = w_prev.tr_en && (w_prev.frac <= w_prev.tf);
                w_xs = w_prev.xs;
                if (STEP == 0) begin
                    // settle the previous trial bit, then try the next one
                    if (w_acc) begin
                        n_st.xg = w_prev.xt;
                    end
                    n_st.tr_en = (4'(TRIAL) <= w_prev.p) && (w_prev.p != 4'd15);
                    n_st.xt = n_st.xg | TRIAL_BIT;
                    n_st.frac = '0;
                    w_xs = n_st.xt;
                end
                w_sq = dag_pkg::sq_step(w_xs);
                n_st.xs = w_sq.x;
                n_st.frac = {n_st.frac[14:0], w_sq.bit_set};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_st[s].meta <= '0;
                end else if (i_en) begin
                    r_st[s] <= n_st;
                end
            end
        end
    endgenerate

    dag_pkg::t_srch w_last;
    logic [30:0]    w_xg;
    logic [30:0]    w_shift;
    logic [15:0]    w_nat;
    logic [15:0]    n_fin_g;

    assign w_last = r_st[dag_pkg::SRCH_STAGES];

    always_comb begin
        w_xg = w_last.xg;
        if (w_last.tr_en && (w_last.frac <= w_last.tf)) begin
            w_xg = w_last.xt;
        end
        w_shift = w_xg >> (5'd30 - {1'b0, w_last.p});
        w_nat = (w_last.p == 4'd15) ? dag_pkg::FULL_GAIN : w_shift[15:0];
        if (w_last.meta.spec) begin
            n_fin_g = w_last.meta.spec_gain;
        end else if (w_last.nat) begin
            n_fin_g = w_nat;
        end else begin
            n_fin_g = w_last.gain_other;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_v <= 1'b0;
        end else if (i_en) begin
            r_fin_v <= w_last.meta.valid;
            r_fin_g <= n_fin_g;
        end
    end

    assign o_valid = r_fin_v;
    assign o_gain = r_fin_g;

endmodule

@@ rtl/distance_attenuation_gain.sv @@
// distance attenuation gain: maps a Q16.8 distance to a Q1.15 gain along a configured curve
// uses dag_pkg, dag_in_if, dag_out_if, dag_nat_search
//
// usage:
//   i_dist_ch carries one distance per beat, o_gain_ch one gain per beat, in order.
//   the register port (i_cfg_we, i_cfg_idx, i_cfg_data) takes one write per cycle and
//   should only be written while no distance is in flight.
// pipeline:
//   a new distance is taken every cycle unless stalled; the depth is set by the 16-step
//   divider, the 16-step log2 squaring chain and the 14 trial bits of the natural-sound
//   search, each step one squaring multiplier or one subtract-compare per stage.
// reset:
//   synchronous, active low; clears all valid bits, attenuation off, curve linear,
//   far edge at -60 dB.
// stall:
//   when o_gain_ch is not ready a two-entry output buffer catches the next result,
//   and only once it is full does i_dist_ch.ready drop and the pipeline freeze;
//   nothing is lost or repeated.
module distance_attenuation_gain (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    dag_in_if.sink      i_dist_ch,
    dag_out_if.source   o_gain_ch
);

    typedef struct packed {
        dag_pkg::t_meta meta;
        logic [15:0]    n16;
        logic [4:0]     e;
        logic [30:0]    x;
        logic [15:0]    frac;
        logic [21:0]    d;
        logic [21:0]    rinv;
        logic [15:0]    qinv;
        logic [30:0]    tt;      // a*n16 at entry, log2 target offset after the first step
    } t_ph2;

    // configuration
    logic        r_atten_en;
    logic [23:0] r_inner;
    logic [23:0] r_falloff;
    logic [2:0]  r_curve;
    logic [15:0] r_db;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atten_en <= 1'b0;
            r_inner <= '0;
            r_falloff <= '0;
            r_curve <= dag_pkg::CURVE_LINEAR;
            r_db <= 16'hC400;
        end else if (i_cfg_we) begin
            unique case (dag_pkg::t_cfg_idx'(i_cfg_idx))
                dag_pkg::CFG_ENABLE:  r_atten_en <= i_cfg_data[0];
                dag_pkg::CFG_INNER:   r_inner <= i_cfg_data;
                dag_pkg::CFG_FALLOFF: r_falloff <= i_cfg_data;
                dag_pkg::CFG_CURVE:   r_curve <= i_cfg_data[2:0];
                dag_pkg::CFG_DB:      r_db <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_skid_v;
    logic [15:0] r_skid_g;
    logic r_out_v;
    logic [15:0] r_out_g;

    assign w_en = !r_skid_v;
    assign i_dist_ch.ready = w_en;

    // entry: special cases and remainder seed
    dag_pkg::t_meta r_dv_meta [0:dag_pkg::DIV_STEPS];
    logic [23:0]    r_dv_rem  [0:dag_pkg::DIV_STEPS];
    logic [15:0]    r_dv_q    [0:dag_pkg::DIV_STEPS];
    dag_pkg::t_meta n_in_meta;
    logic [24:0]    w_outer;

    assign w_outer = {1'b0, r_inner} + {1'b0, r_falloff};

    always_comb begin
        n_in_meta.valid = i_dist_ch.valid;
        n_in_meta.spec = 1'b1;
        n_in_meta.spec_gain = dag_pkg::FULL_GAIN;
        if (!r_atten_en || (i_dist_ch.distance <= r_inner)) begin
            n_in_meta.spec_gain = dag_pkg::FULL_GAIN;
        end else if ((r_falloff == '0) || ({1'b0, i_dist_ch.distance} >= w_outer)) begin
            n_in_meta.spec_gain = '0;
        end else begin
            n_in_meta.spec = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_meta[0] <= '0;
        end else if (w_en) begin
            r_dv_meta[0] <= n_in_meta;
            r_dv_rem[0] <= i_dist_ch.distance - r_inner;
            r_dv_q[0] <= '0;
        end
    end

    // normalized distance: (distance-inner)*2^16 / falloff, one quotient bit a stage
    genvar k;
    generate
        for (k = 1; k <= dag_pkg::DIV_STEPS; k++) begin : g_div
            logic [24:0] w_r2;
            logic        w_ge;
            logic [24:0] w_sub;
            assign w_r2 = {r_dv_rem[k-1], 1'b0};
            assign w_ge = w_r2 >= {1'b0, r_falloff};
            assign w_sub = w_r2 - {1'b0, r_falloff};
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_meta[k] <= '0;
                end else if (w_en) begin
                    r_dv_meta[k] <= r_dv_meta[k-1];
                    r_dv_rem[k] <= w_ge ? w_sub[23:0] : w_r2[23:0];
                    r_dv_q[k] <= {r_dv_q[k-1][14:0], w_ge};
                end
            end
        end
    endgenerate

    // prep: log2 operand, inverse divisor, dB product
    t_ph2        r_ph [0:dag_pkg::LOG_STEPS];
    t_ph2        n_prep;
    logic [15:0] w_n16;
    logic [16:0] w_v;
    logic [46:0] w_xw;
    logic [15:0] w_a;
    logic [31:0] w_an;

    assign w_n16 = r_dv_q[dag_pkg::DIV_STEPS];

    always_comb begin
        n_prep = '0;
        n_prep.meta = r_dv_meta[dag_pkg::DIV_STEPS];
        n_prep.n16 = w_n16;
        if (dag_pkg::t_curve'(r_curve) == dag_pkg::CURVE_LOG_REV) begin
            w_v = 17'h10000 - {1'b0, w_n16};
        end else begin
            w_v = {1'b0, w_n16};
        end
        for (int b = 0; b < 17; b++) begin
            if (w_v[b]) begin
                n_prep.e = 5'(b);
            end
        end
        w_xw = {30'b0, w_v} << (5'd30 - n_prep.e);
        n_prep.x = w_xw[30:0];
        n_prep.d = 22'd65536 + 22'(w_n16) * 22'd50;
        n_prep.rinv = 22'd32768;
        w_a = r_db[15] ? 16'(-r_db) : 16'd0;
        w_an = w_a * w_n16;
        n_prep.tt = w_an[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph[0].meta <= '0;
        end else if (w_en) begin
            r_ph[0] <= n_prep;
        end
    end

    // log2 squaring chain and inverse-curve divider side by side
    generate
        for (k = 1; k <= dag_pkg::LOG_STEPS; k++) begin : g_ph2
            t_ph2          n_st;
            dag_pkg::t_sq  w_sq;
            logic [22:0]   w_r2;
            logic          w_ge;
            logic [22:0]   w_sub;
            logic [60:0]   w_tp;
            always_comb begin
                n_st = r_ph[k-1];
                w_sq = dag_pkg::sq_step(r_ph[k-1].x);
                n_st.x = w_sq.x;
                n_st.frac = {r_ph[k-1].frac[14:0], w_sq.bit_set};
                w_r2 = {r_ph[k-1].rinv, 1'b0};
                w_ge = w_r2 >= {1'b0, r_ph[k-1].d};
                w_sub = w_r2 - {1'b0, r_ph[k-1].d};
                n_st.rinv = w_ge ? w_sub[21:0] : w_r2[21:0];
                n_st.qinv = {r_ph[k-1].qinv[14:0], w_ge};
                w_tp = '0;
                if (k == 1) begin
                    w_tp = 61'(r_ph[k-1].tt) * 61'(dag_pkg::LOG2_10_OVER_20);
                    n_st.tt = {10'b0, w_tp[60:40]};
                end
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ph[k].meta <= '0;
                end else if (w_en) begin
                    r_ph[k] <= n_st;
                end
            end
        end
    endgenerate

    // curve evaluation and natural-sound target
    t_ph2           w_p2;
    dag_pkg::t_srch n_sr;
    dag_pkg::t_srch r_sr;
    logic [20:0]    w_lg;
    logic [20:0]    w_ldiff;
    logic [36:0]    w_lprod;
    logic [18:0]    w_vl;
    logic [16:0]    w_lin;
    logic [20:0]    w_t;
    logic [21:0]    w_tg;

    assign w_p2 = r_ph[dag_pkg::LOG_STEPS];

    always_comb begin
        w_lg = {w_p2.e, w_p2.frac};
        w_ldiff = 21'h100000 - w_lg;
        w_lprod = 37'(w_ldiff) * 37'(dag_pkg::LN2_Q16);
        w_vl = w_lprod[36:18];
        w_lin = 17'h10000 - {1'b0, w_p2.n16};
        w_t = w_p2.tt[20:0];
        w_tg = {1'b0, dag_pkg::NAT_TOP} - {1'b0, w_t};

        n_sr = '0;
        n_sr.meta = w_p2.meta;
        n_sr.p = w_tg[19:16];
        n_sr.tf = w_tg[15:0];
        n_sr.xg = 31'h40000000;
        n_sr.xt = 31'h40000000;
        case (dag_pkg::t_curve'(r_curve))
            dag_pkg::CURVE_LOG: begin
                n_sr.gain_other = (w_vl > 19'd32768) ? dag_pkg::FULL_GAIN : w_vl[15:0];
            end
            dag_pkg::CURVE_INVERSE: begin
                n_sr.gain_other = w_p2.qinv;
            end
            dag_pkg::CURVE_LOG_REV: begin
                n_sr.gain_other = (w_vl >= 19'd32768) ? 16'd0
                                                      : dag_pkg::FULL_GAIN - w_vl[15:0];
            end
            dag_pkg::CURVE_NATURAL: begin
                n_sr.nat = 1'b1;
                // target below zero: silent
                if (w_t > dag_pkg::NAT_TOP && !w_p2.meta.spec) begin
                    n_sr.meta.spec = 1'b1;
                    n_sr.meta.spec_gain = '0;
                end
            end
            default: begin
                n_sr.gain_other = w_lin[16:1];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr.meta <= '0;
        end else if (w_en) begin
            r_sr <= n_sr;
        end
    end

    logic        w_fin_v;
    logic [15:0] w_fin_g;

    dag_nat_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_st    (r_sr),
        .o_valid (w_fin_v),
        .o_gain  (w_fin_g)
    );

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || o_gain_ch.ready) begin
            if (r_skid_v) begin
                r_out_v <= 1'b1;
                r_out_g <= r_skid_g;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= w_fin_v;
                r_out_g <= w_fin_g;
            end
        end else if (w_fin_v && w_en) begin
            r_skid_v <= 1'b1;
            r_skid_g <= w_fin_g;
        end
    end

    assign o_gain_ch.valid = r_out_v;
    assign o_gain_ch.gain = r_out_g;

endmodule

@@ rtl/dag_checker.sv @@
// port-level checks for distance_attenuation_gain, attached by bind
// depends on the top level's channel ports only
module dag_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_gain
);

    // input only backs up while a result sits unclaimed
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !$past(i_out_ready)))
        else $error("input stalled without a waiting result");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_gain <= 16'h8000))
        else $error("gain above full scale");

    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) && i_rst_n |-> !i_out_valid && i_in_ready)
        else $error("output valid or input blocked right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_gain))
        else $error("stalled output beat changed");

    a_known_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({i_in_valid, i_out_valid}))
        else $error("channel valid unknown");

endmodule

bind distance_attenuation_gain dag_checker u_dag_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_dist_ch.valid),
    .i_in_ready  (i_dist_ch.ready),
    .i_out_valid (o_gain_ch.valid),
    .i_out_ready (o_gain_ch.ready),
    .i_gain      (o_gain_ch.gain)
);

@@ tb/tb_dag_gain_sb.sv @@
// gain scoreboard: bit-exact distance-to-gain predictor and in-order expected gain queue
// depends on dag_pkg for the curve and register codes
`timescale 1ns / 100ps

class dag_gain_sb;
    bit          atten_on;
    logic [23:0] inner;
    logic [23:0] falloff;
    logic [2:0]  curve;
    logic [15:0] db_far;
    logic [15:0] pending_gains[$];
    int          errors;

    function new();
        atten_on = 1'b0;
        inner = '0;
        falloff = '0;
        curve = dag_pkg::CURVE_LINEAR;
        db_far = 16'(65536 - 15360);
        errors = 0;
    endfunction

    function void set_reg(dag_pkg::t_cfg_idx idx, logic [23:0] data);
        case (idx)
            dag_pkg::CFG_ENABLE:  atten_on = data[0];
            dag_pkg::CFG_INNER:   inner = data;
            dag_pkg::CFG_FALLOFF: falloff = data;
            dag_pkg::CFG_CURVE:   curve = data[2:0];
            dag_pkg::CFG_DB:      db_far = data[15:0];
            default: ;
        endcase
    endfunction

    // log2 in Q.16 by repeated squaring
    function automatic logic [31:0] log2_q16(logic [31:0] v);
        logic [31:0] e;
        logic [15:0] frac;
        logic [63:0] x;
        e = 0;
        frac = 0;
        if (v == 0) return 0;
        while (e < 31 && (v >> (e + 1)) != 0) e++;
        if (e > 30) e = 30;
        x = 64'(v) << (30 - e);
        for (int i = 15; i >= 0; i--) begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31)) begin
                frac[i] = 1'b1;
                x = x >> 1;
            end
        end
        return (e << 16) | 32'(frac);
    endfunction

    function automatic logic [15:0] natural_gain(logic [31:0] n16);
        logic [63:0] a;
        logic [63:0] t;
        longint      target;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mid;
        lo = 1;
        hi = 32768;
        a = db_far[15] ? 64'(-$signed({16'hffff, db_far})) : 64'd0;
        t = ((a * 64'(n16)) * 64'd713378625) >> 40;
        target = longint'(15 << 16) - longint'(t);
        if (target < 0) return 0;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (longint'(log2_q16(mid)) <= target) lo = mid;
            else hi = mid - 1;
        end
        return lo[15:0];
    endfunction

    function automatic logic [15:0] gain_for(logic [23:0] d);
        logic [31:0] n16;
        logic [63:0] v;
        if (!atten_on || d <= inner) return 16'h8000;
        if (falloff == 0) return 0;
        if (25'(d) >= 25'(inner) + 25'(falloff)) return 0;
        n16 = 32'((64'(d - inner) << 16) / 64'(falloff));
        if (n16 > 65535) n16 = 65535;
        case (curve)
            dag_pkg::CURVE_LOG: begin
                if (n16 == 0) return 16'h8000;
                v = (64'((32'd16 << 16) - log2_q16(n16)) * 64'd45426) >> 18;
                return v > 32768 ? 16'h8000 : v[15:0];
            end
            dag_pkg::CURVE_INVERSE:
                return 16'((64'd1 << 31) / (64'd65536 + 64'd50 * n16));
            dag_pkg::CURVE_LOG_REV: begin
                v = (64'((32'd16 << 16) - log2_q16(65536 - n16)) * 64'd45426) >> 18;
                return v >= 32768 ? 16'd0 : 16'(32768 - v);
            end
            dag_pkg::CURVE_NATURAL: return natural_gain(n16);
            default: return 16'((65536 - n16) >> 1);
        endcase
    endfunction

    function void note_distance(logic [23:0] d);
        pending_gains.push_back(gain_for(d));
    endfunction

    function void check_gain(logic [15:0] got);
        logic [15:0] want;
        if (pending_gains.size() == 0) begin
            $display("%0t: gain %0d with none expected", $time, got);
            errors++;
            return;
        end
        want = pending_gains.pop_front();
        if (got !== want) begin
            $display("%0t: gain mismatch expected %0d actual %0d", $time, want, got);
            errors++;
        end
    endfunction
endclass

@@ tb/tb_top.sv @@
// top of the distance gain regression: drives distances and registers, checks gains
// depends on dag_pkg, dag_in_if, dag_out_if, distance_attenuation_gain, tb_dag_gain_sb.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int WATCHDOG = 20000;
    localparam int DRAIN = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [23:0] i_cfg_data;
    dag_in_if    dist_ch ();
    dag_out_if   gain_ch ();
    dag_gain_sb  sb;
    int          idle_cycles = 0;

    distance_attenuation_gain i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_dist_ch  (dist_ch.sink),
        .o_gain_ch  (gain_ch.source)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = dag_pkg::CFG_ENABLE;
        i_cfg_data = '0;
        dist_ch.valid = 1'b0;
        dist_ch.distance = '0;
        gain_ch.ready = 1'b0;
    end

    // accepted beats on both channels, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (dist_ch.valid && dist_ch.ready) sb.note_distance(dist_ch.distance);
            if (gain_ch.valid && gain_ch.ready) sb.check_gain(gain_ch.gain);
        end
    end

    // receiver stalls at random, with a no-stall stretch
    initial begin
        int gap;
        int beats;
        beats = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = (beats > 300 && beats < 500) ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                gain_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            gain_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!gain_ch.valid) @(posedge i_clk);
            beats++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (dist_ch.valid && dist_ch.ready) || (gain_ch.valid && gain_ch.ready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("distance_attenuation_gain regression: fail");
            $finish;
        end
    end

    task automatic write_reg(dag_pkg::t_cfg_idx idx, logic [23:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending_gains.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_all(bit en, logic [23:0] inr, logic [23:0] fall, dag_pkg::t_curve c,
                           logic [15:0] db);
        wait_drained();
        write_reg(dag_pkg::CFG_ENABLE, 24'(en));
        write_reg(dag_pkg::CFG_INNER, inr);
        write_reg(dag_pkg::CFG_FALLOFF, fall);
        write_reg(dag_pkg::CFG_CURVE, 24'(c));
        write_reg(dag_pkg::CFG_DB, {8'h00, db});
    endtask

    // one distance beat; the random gap may be zero so valid stays high across beats
    task automatic send_distance(logic [23:0] d, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 11) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            dist_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        dist_ch.valid <= 1'b1;
        dist_ch.distance <= d;
        @(posedge i_clk);
        while (!dist_ch.ready) @(posedge i_clk);
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        dist_ch.valid <= 1'b0;
    endtask

    function automatic logic [23:0] pick_distance(logic [23:0] inr, logic [23:0] fall);
        logic [24:0] outer;
        outer = 25'(inr) + 25'(fall);
        case ($urandom_range(0, 9))
            0: return 24'($urandom);
            1: return inr;
            2: return (outer > 25'hffffff) ? 24'hffffff : outer[23:0];
            3: return inr - 24'($urandom_range(0, 3));
            default:
                return (fall == 0) ? 24'($urandom)
                     : 24'(25'(inr) + 25'($urandom % fall));
        endcase
    endfunction

    function automatic logic [23:0] pick_len();
        case ($urandom_range(0, 5))
            0: return 24'($urandom_range(1, 16));
            1: return 24'hffffff;
            2: return 24'($urandom);
            default: return 24'($urandom_range(1, 24'h40000));
        endcase
    endfunction

    initial begin
        logic [23:0]     inr;
        logic [23:0]     fall;
        dag_pkg::t_curve c;
        logic [15:0]     db;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: attenuation off gives full gain
        send_distance(24'h0, 0);
        send_distance(24'hffffff, 0);
        end_burst();
        // zero falloff outside the inner radius
        set_all(1, 24'h100, 24'h0, dag_pkg::CURVE_LINEAR, 16'hc400);
        send_distance(24'h100, 0);
        send_distance(24'h101, 0);
        send_distance(24'hffffff, 0);
        end_burst();
        // every curve near the inner edge, mid, and the outer edge
        for (int k = 0; k <= 5; k++) begin
            set_all(1, 24'h10, 24'h1000, dag_pkg::t_curve'(k),
                    (k == 4) ? 16'h8000 : 16'hc400);
            send_distance(24'h11, 0);
            send_distance(24'h800, 0);
            send_distance(24'h100f, 0);
            send_distance(24'h1010, 0);
            end_burst();
        end
        // outer edge beyond 24 bits, positive dB treated as zero, curve codes 6 and 7
        set_all(1, 24'hfffff0, 24'hffffff, dag_pkg::CURVE_NATURAL, 16'h0100);
        send_distance(24'hffffff, 0);
        end_burst();
        wait_drained();
        write_reg(dag_pkg::CFG_CURVE, 24'd6);
        send_distance(24'hfffff8, 0);
        end_burst();
        wait_drained();
        write_reg(dag_pkg::CFG_CURVE, 24'd7);
        send_distance(24'hfffff8, 0);
        end_burst();

        for (int ph = 0; ph < 30; ph++) begin
            inr = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4096));
            fall = pick_len();
            c = dag_pkg::t_curve'($urandom_range(0, 5));
            db = ($urandom_range(0, 3) == 0) ? 16'h8000 : 16'(-$urandom_range(0, 32768));
            set_all($urandom_range(0, 7) != 0, inr, fall, c, db);
            for (int n = 0; n < 60; n++) begin
                // quiet stretch without sender gaps every few phases
                send_distance(pick_distance(inr, fall), (ph % 4) != 1);
                if (ph == 7 && n == 30) begin
                    end_burst();
                    while (sb.pending_gains.size() != 0) @(posedge i_clk);
                end
            end
            end_burst();
        end
        wait_drained();
        if (sb.errors == 0 && sb.pending_gains.size() == 0)
            $display("distance_attenuation_gain regression: pass");
        else
            $display("distance_attenuation_gain regression: fail");
        $finish;
    end
endmodule

@@ files.f @@
rtl/dag_pkg.sv
rtl/dag_in_if.sv
rtl/dag_out_if.sv
rtl/dag_nat_search.sv
rtl/distance_attenuation_gain.sv
rtl/dag_checker.sv
tb/tb_dag_gain_sb.sv
tb/tb_top.sv
